// File: src/bpfa_pkg.sv
// shared types, constants and command codes of the page frame allocator
package bpfa_pkg;

  // sizes
  localparam int unsigned PAGES_DEF = 1048576;
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned LANES     = 8;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned PAGE_W    = 20;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned LIMIT_W   = 18;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // register map
  localparam logic [APB_AW-1:0] ADDR_TOTAL_PAGES = 3'd0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PAGE_W-1:0] page_number;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [PAGE_W-1:0]  result_page;
    logic [COUNT_W-1:0] pages_used;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_e;

endpackage

// File: src/bpfa_ram.sv
// bitmap storage: one write port, one read port with registered read data
module bpfa_ram #(
  parameter int unsigned DEPTH = bpfa_pkg::PAGES_DEF / bpfa_pkg::ROW_W,
  parameter int unsigned AW    = $clog2(bpfa_pkg::PAGES_DEF / bpfa_pkg::ROW_W)
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [bpfa_pkg::ROW_W-1:0]   rd_data_o,
  input  logic                         wr_en_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [bpfa_pkg::ROW_W-1:0]   wr_data_i
);

  logic [bpfa_pkg::ROW_W-1:0] mem_q [DEPTH];
  logic [bpfa_pkg::ROW_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/bpfa_ctrl.sv
// sequencer: clearing pass, row scan, read-modify-write and result register
module bpfa_ctrl #(
  parameter int unsigned PAGES = bpfa_pkg::PAGES_DEF,
  parameter int unsigned DEPTH = bpfa_pkg::PAGES_DEF / bpfa_pkg::ROW_W,
  parameter int unsigned AW    = $clog2(bpfa_pkg::PAGES_DEF / bpfa_pkg::ROW_W)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bpfa_pkg::COUNT_W-1:0]     total_pages_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bpfa_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bpfa_pkg::out_word_t              out_word_o,
  output logic                             rd_en_o,
  output logic [AW-1:0]                    rd_addr_o,
  input  logic [bpfa_pkg::ROW_W-1:0]       rd_data_i,
  output logic                             wr_en_o,
  output logic [AW-1:0]                    wr_addr_o,
  output logic [bpfa_pkg::ROW_W-1:0]       wr_data_o
);

  localparam int unsigned RW = bpfa_pkg::ROW_W;
  localparam int unsigned LW = bpfa_pkg::LIMIT_W;
  localparam int unsigned CW = bpfa_pkg::COUNT_W;
  localparam int unsigned PW = bpfa_pkg::PAGE_W;
  localparam int unsigned BW = bpfa_pkg::BIT_W;
  localparam int unsigned NL = bpfa_pkg::LANES;

  localparam logic [LW-1:0] BYTE_CAP = LW'(PAGES / 8);
  localparam logic [CW-1:0] PAGE_CNT = CW'(PAGES);
  localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

  bpfa_pkg::state_e state_q, state_d;

  logic [bpfa_pkg::CMD_W-1:0] cmd_q;
  logic [PW-1:0]              pg_q;
  logic                       pg_ok_q;
  logic [LW-1:0]              lim_q;
  logic [AW-1:0]              addr_q;
  logic [AW-1:0]              clr_q;
  logic [CW-1:0]              used_q;
  logic                       out_valid_q;
  bpfa_pkg::out_word_t        out_q;

  logic              in_accept;
  logic [LW-1:0]     lim_in;
  logic [NL-1:0]     lane_ok;
  logic [RW-1:0]     masked;
  logic [RW-1:0]     free_bits;
  logic [RW-1:0]     lowest;
  logic [BW-1:0]     idx;
  logic              hit;
  logic              more;
  logic [AW-1:0]     next_row;
  logic [RW-1:0]     pg_bit;
  logic              is_alloc;
  logic              finish;
  logic              can_out;
  logic              complete;
  logic              write_needed;
  logic              used_inc;
  logic [CW-1:0]     used_next;
  logic [RW-1:0]     row_new;
  bpfa_pkg::out_word_t result;

  assign in_accept = in_valid_i && !in_stall_o;
  assign lim_in    = (total_pages_i[CW-1:3] < BYTE_CAP) ? total_pages_i[CW-1:3] : BYTE_CAP;

  // only bytes below the search bound take part, the rest look full
  always_comb begin
    lane_ok   = '0;
    masked    = '0;
    for (int k = 0; k < NL; k++) begin
      lane_ok[k]       = (LW'({addr_q, 3'(k)}) < lim_q);
      masked[k*8 +: 8] = rd_data_i[k*8 +: 8] | {8{~lane_ok[k]}};
    end
  end

  assign free_bits = ~masked;
  assign lowest    = free_bits & (~free_bits + RW'(1));
  assign hit       = |free_bits;

  always_comb begin
    idx = '0;
    for (int i = 0; i < RW; i++) begin
      if (lowest[i]) begin
        idx = idx | BW'(i);
      end
    end
  end

  assign next_row = addr_q + AW'(1);
  assign more     = ((LW'(addr_q) + LW'(1)) << 3) < lim_q;
  assign pg_bit   = RW'(1) << pg_q[BW-1:0];
  assign is_alloc = (cmd_q == bpfa_pkg::CMD_ALLOC);
  assign finish   = !is_alloc || hit || !more;
  assign can_out  = !out_valid_q || !out_stall_i;
  assign complete = (state_q == bpfa_pkg::ST_CHECK) && finish && can_out;

  assign write_needed = is_alloc ? hit
                      : (((cmd_q == bpfa_pkg::CMD_RESERVE) || (cmd_q == bpfa_pkg::CMD_RELEASE))
                         && pg_ok_q);

  assign used_inc  = (is_alloc && hit) || ((cmd_q == bpfa_pkg::CMD_RESERVE) && pg_ok_q);
  assign used_next = (used_inc && (used_q < PAGE_CNT)) ? used_q + CW'(1) : used_q;

  always_comb begin
    case (cmd_q)
      bpfa_pkg::CMD_ALLOC:   row_new = rd_data_i | lowest;
      bpfa_pkg::CMD_RESERVE: row_new = rd_data_i | pg_bit;
      bpfa_pkg::CMD_RELEASE: row_new = rd_data_i & ~pg_bit;
      default:               row_new = rd_data_i;
    endcase
  end

  always_comb begin
    result.found       = is_alloc && hit;
    result.result_page = is_alloc ? (hit ? PW'({addr_q, idx}) : '0) : pg_q;
    result.pages_used  = used_next;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        if (clr_q == LAST_ROW) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      bpfa_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = bpfa_pkg::ST_READ;
        end
      end
      bpfa_pkg::ST_READ: begin
        state_d = bpfa_pkg::ST_CHECK;
      end
      bpfa_pkg::ST_CHECK: begin
        if (complete) begin
          state_d = bpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bpfa_pkg::ST_CLEAR;
      end
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_stall_o = 1'b1;
    rd_en_o    = 1'b0;
    rd_addr_o  = addr_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = addr_q;
    wr_data_o  = row_new;
    case (state_q)
      bpfa_pkg::ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = '1;
      end
      bpfa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      bpfa_pkg::ST_READ: begin
        rd_en_o = 1'b1;
      end
      bpfa_pkg::ST_CHECK: begin
        if (!finish) begin
          rd_en_o   = 1'b1;
          rd_addr_o = next_row;
        end
        wr_en_o = complete && write_needed;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfa_pkg::ST_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bpfa_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (complete) begin
        used_q      <= used_next;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= in_word_i.command;
      pg_q    <= in_word_i.page_number;
      pg_ok_q <= (CW'(in_word_i.page_number) < PAGE_CNT);
      lim_q   <= lim_in;
      addr_q  <= (in_word_i.command == bpfa_pkg::CMD_ALLOC) ? '0
                                                           : in_word_i.page_number[AW+BW-1:BW];
    end else if ((state_q == bpfa_pkg::ST_CHECK) && !finish) begin
      addr_q <= next_row;
    end
    if (complete) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: src/bitmap_page_frame_allocator.sv
// top level: page frame allocator with apb configuration, sequencer and bitmap memory
// sequence: reserve, release and no-op words read their row, then check it and register the result;
//   allocate reads 64-page rows in turn until a free bit shows or the bound is reached
// throughput: one word at a time; the next word is accepted the cycle after a result is
//   registered, even while that result still waits on out_stall_i
// reset: clearing pass writes all ones to each of DEPTH rows (16384 by default), in_stall_o high
module bitmap_page_frame_allocator #(
  parameter int unsigned PAGES = bpfa_pkg::PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // apb configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpfa_pkg::APB_AW-1:0]      paddr,
  input  logic [bpfa_pkg::APB_DW-1:0]      pwdata,
  output logic [bpfa_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  // command channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bpfa_pkg::in_word_t               in_word_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bpfa_pkg::out_word_t              out_word_o
);

  localparam int unsigned RW    = bpfa_pkg::ROW_W;
  localparam int unsigned CW    = bpfa_pkg::COUNT_W;
  localparam int unsigned DW    = bpfa_pkg::APB_DW;
  // one memory row holds 64 page bits, eight bitmap bytes
  localparam int unsigned DEPTH = (PAGES + RW - 1) / RW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0] total_pages_q;
  logic          cfg_write;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;

  // configuration register, writes complete in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_pages_q <= '0;
    end else if (cfg_write && (paddr == bpfa_pkg::ADDR_TOTAL_PAGES)) begin
      total_pages_q <= pwdata[CW-1:0];
    end
  end

  // readback, addresses past the register map read zero
  assign prdata = (paddr == bpfa_pkg::ADDR_TOTAL_PAGES) ? DW'(total_pages_q) : '0;

  // sequencer: owns the command handshake, the scan and the result register
  bpfa_ctrl #(
    .PAGES (PAGES),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .total_pages_i (total_pages_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data)
  );

  // used-page bitmap, one bit per page, set means in use or reserved
  bpfa_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // an accepted word keeps the block busy on the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("command taken while a previous one is in flight");

  // the clearing pass holds off commands right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> in_stall_o)
    else $error("command port open before the bitmap was cleared");

  // an allocated page lies inside the bitmap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.found) |-> (CW'(out_word_o.result_page) < CW'(PAGES)))
    else $error("allocated page outside the bitmap");

  // the used count saturates at the page count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.pages_used <= CW'(PAGES)))
    else $error("used count above the page count");

endmodule

// File: tb/sv/tb.sv
// self-checking testbench of the bitmap page frame allocator: directed table, then random phases
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  // command code 3 has no meaning in the block, it just echoes the page
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam int unsigned ROWS = PAGES_DEF / 64;

  // one line of the directed table: search bound to apply first, the word to send,
  // and a hand-typed result where it is obvious, otherwise the predictor decides
  typedef struct packed {
    logic [COUNT_W-1:0] total;
    logic [CMD_W-1:0]   cmd;
    logic [PAGE_W-1:0]  page;
    logic               typed;
    out_word_t          want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [25] = '{
    // after reset: bound of zero, every page marked used
    '{21'd0,       CMD_ALLOC,   20'h00000, 1'b1, '{1'b0, 20'h00000, 21'd0}},
    '{21'd0,       CMD_NOP,     20'hFFFFF, 1'b1, '{1'b0, 20'hFFFFF, 21'd0}},
    // reserve of a page already set still counts
    '{21'd0,       CMD_RESERVE, 20'h00000, 1'b1, '{1'b0, 20'h00000, 21'd1}},
    '{21'd0,       CMD_RESERVE, 20'hFFFFF, 1'b1, '{1'b0, 20'hFFFFF, 21'd2}},
    // release leaves the count alone
    '{21'd0,       CMD_RELEASE, 20'h00000, 1'b1, '{1'b0, 20'h00000, 21'd2}},
    // page 0 is free now, but a zero bound searches nothing
    '{21'd0,       CMD_ALLOC,   20'h00000, 1'b1, '{1'b0, 20'h00000, 21'd2}},
    // one byte searched; the page field of an allocate is ignored
    '{21'd8,       CMD_ALLOC,   20'h00005, 1'b1, '{1'b1, 20'h00000, 21'd3}},
    '{21'd8,       CMD_ALLOC,   20'h00000, 1'b1, '{1'b0, 20'h00000, 21'd3}},
    '{21'd8,       CMD_RELEASE, 20'h00007, 1'b0, '0},
    '{21'd8,       CMD_RELEASE, 20'h00003, 1'b0, '0},
    '{21'd8,       CMD_ALLOC,   20'h00000, 1'b0, '0},
    // bound not a multiple of eight: partial byte is never searched
    '{21'd13,      CMD_RELEASE, 20'h00008, 1'b0, '0},
    '{21'd13,      CMD_ALLOC,   20'h00000, 1'b0, '0},
    '{21'd13,      CMD_ALLOC,   20'h00000, 1'b0, '0},
    '{21'd13,      CMD_NOP,     20'h5A5A5, 1'b0, '0},
    // bound beyond the bitmap: the scan stops at the last byte
    '{21'h1FFFFF,  CMD_RELEASE, 20'hFFFFF, 1'b0, '0},
    '{21'h1FFFFF,  CMD_ALLOC,   20'h00000, 1'b0, '0},
    '{21'h1FFFFF,  CMD_ALLOC,   20'h00000, 1'b0, '0},
    '{21'h1FFFFF,  CMD_ALLOC,   20'h00000, 1'b0, '0},
    '{21'h1FFFFF,  CMD_RESERVE, 20'h55555, 1'b0, '0},
    '{21'h1FFFFF,  CMD_RELEASE, 20'hAAAAA, 1'b0, '0},
    // full-size bound: lone free page deep in the bitmap, then nothing free
    '{21'd1048576, CMD_ALLOC,   20'h00000, 1'b0, '0},
    '{21'd1048576, CMD_RELEASE, 20'h00001, 1'b0, '0},
    '{21'd1048576, CMD_RESERVE, 20'h00001, 1'b0, '0},
    '{21'd1048576, CMD_ALLOC,   20'h00000, 1'b0, '0}
  };

  // search bounds of the random phases; the wide ones get few words since a
  // fruitless allocate walks all 16384 rows
  localparam logic [COUNT_W-1:0] PHASE_TOTALS [10] = '{
    21'd64, 21'd8, 21'd1000, 21'd37, 21'd4096, 21'd0, 21'h1FFFFF, 21'd513,
    21'd1048576, 21'd200
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_word_t           in_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_word_t          out_word_o;

  // shadow of the allocator: used-page bitmap in rows of 64, count and bound
  logic [63:0]        used_map [ROWS];
  logic [COUNT_W-1:0] used_pages = '0;
  logic [COUNT_W-1:0] total_cfg = '0;

  // results owed by the block, oldest first
  out_word_t          due_results [$];

  int unsigned        words_sent = 0;
  int unsigned        words_got = 0;
  int unsigned        mismatches = 0;
  int unsigned        hold_left = 0;
  bit                 hold_done = 1'b0;

  always #5 clk_i = ~clk_i;

  bitmap_page_frame_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  function automatic void flag_mismatch(input string msg);
    if (mismatches < 10) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endfunction

  function automatic void count_page();
    if (used_pages < PAGES_DEF) begin
      used_pages++;
    end
  endfunction

  // applies one command word to the shadow bitmap and returns the result it owes;
  // a 20-bit page is always below the default page count, so no range check
  function automatic out_word_t allocator_step(input in_word_t w);
    out_word_t   r;
    int unsigned limit_bytes;
    int unsigned row;
    int unsigned b;
    int unsigned nbits;
    bit          hit;
    r.found       = 1'b0;
    r.result_page = w.page_number;
    hit           = 1'b0;
    case (w.command)
      CMD_ALLOC: begin
        r.result_page = '0;
        limit_bytes   = total_cfg >> 3;
        if (limit_bytes > PAGES_DEF / 8) begin
          limit_bytes = PAGES_DEF / 8;
        end
        // lowest page first: rows upward, bits upward within a row
        for (row = 0; row * 8 < limit_bytes && !hit; row++) begin
          nbits = (limit_bytes - row * 8 >= 8) ? 64 : (limit_bytes - row * 8) * 8;
          if (used_map[row] != '1) begin
            for (b = 0; b < nbits && !hit; b++) begin
              if (!used_map[row][b]) begin
                hit              = 1'b1;
                used_map[row][b] = 1'b1;
                r.found          = 1'b1;
                r.result_page    = PAGE_W'(row * 64 + b);
                count_page();
              end
            end
          end
        end
      end
      CMD_RESERVE: begin
        used_map[w.page_number[PAGE_W-1:6]][w.page_number[5:0]] = 1'b1;
        count_page();
      end
      CMD_RELEASE: begin
        used_map[w.page_number[PAGE_W-1:6]][w.page_number[5:0]] = 1'b0;
      end
      default: begin
      end
    endcase
    r.pages_used = used_pages;
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input bit wide);
    int unsigned r;
    r = $urandom_range(99);
    if (r < (wide ? 25 : 35)) return CMD_ALLOC;
    if (r < 55) return CMD_RESERVE;
    if (r < 90) return CMD_RELEASE;
    return CMD_NOP;
  endfunction

  // mostly pages near the search bound so that releases feed allocates,
  // the rest anywhere so every page bit flips
  function automatic logic [PAGE_W-1:0] pick_page(input int unsigned span);
    if ($urandom_range(99) < 75) return PAGE_W'($urandom_range(span - 1));
    return PAGE_W'($urandom);
  endfunction

  // sender side: random gaps except in the calm stretch, valid held until taken
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t given);
    out_word_t pred;
    while (!(words_sent >= 300 && words_sent < 400) && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pred = allocator_step(w);
    due_results.push_back(typed ? given : pred);
    words_sent++;
  endtask

  // drain the block, then write the search bound and read it back; the read
  // setup follows the write access directly so psel stays up
  task automatic set_total(input logic [COUNT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TOTAL_PAGES;
    pwdata  <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    total_cfg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[COUNT_W-1:0] !== v) begin
      flag_mismatch($sformatf("total_pages readback want %0d got %0d",
                              v, prdata[COUNT_W-1:0]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver side: checks every taken word against the oldest owed result,
  // stalls at random, and once holds off long enough to back the block up
  initial begin : result_side
    out_word_t want;
    out_word_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = out_word_o;
        words_got++;
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected word found=%0b page=%05h used=%0d",
                                  got.found, got.result_page, got.pages_used));
        end else begin
          want = due_results.pop_front();
          if (got.found !== want.found || got.result_page !== want.result_page ||
              got.pages_used !== want.pages_used) begin
            flag_mismatch($sformatf(
              "word %0d want found=%0b page=%05h used=%0d, got found=%0b page=%05h used=%0d",
              words_got, want.found, want.result_page, want.pages_used,
              got.found, got.result_page, got.pages_used));
          end
        end
        // long hold-off while the sender keeps offering words
        if (words_got == 150 && !hold_done) begin
          hold_left = 300;
          hold_done = 1'b1;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !(words_got >= 300 && words_got < 400) && ($urandom_range(99) < 11);
      end
    end
  end

  initial begin : stimulus
    in_word_t    w;
    int unsigned n_words;
    int unsigned span;
    bit          wide;
    foreach (used_map[k]) used_map[k] = '1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; the block clears its bitmap first and stalls meanwhile
    foreach (DIR_TAB[k]) begin
      if (DIR_TAB[k].total != total_cfg) begin
        set_total(DIR_TAB[k].total);
      end
      w.command     = DIR_TAB[k].cmd;
      w.page_number = DIR_TAB[k].page;
      push_word(w, DIR_TAB[k].typed, DIR_TAB[k].want);
    end

    // random phases, one search bound each
    foreach (PHASE_TOTALS[p]) begin
      set_total(PHASE_TOTALS[p]);
      wide    = PHASE_TOTALS[p] > 8192;
      n_words = wide ? 16 : 70;
      span    = wide ? 4096 : PHASE_TOTALS[p] + 16;
      repeat (n_words) begin
        w.command     = pick_cmd(wide);
        w.page_number = pick_page(span);
        push_word(w, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // a few more cycles to catch any stray result
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // generous bound: clearing pass plus a handful of full-bitmap scans
  initial begin : watchdog
    #50ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
